// ===== sv/gfc_pkg.sv =====
// ----------------------------------------------------------------------------
// gfc_pkg
// Shared types and codes for the GIF frame compositor: the command that
// travels from the front end through the queue to the back end, and the
// canvas geometry in effect.
// ----------------------------------------------------------------------------
package gfc_pkg;

    // widest coordinate and canvas address over the legal parameter range
    localparam int COORD_W = 13;
    localparam int ADDR_W  = 24;

    // back-end operation codes
    localparam logic [2:0] K_PAL  = 3'd0;  // palette write
    localparam logic [2:0] K_PIX  = 3'd1;  // opaque pixel write
    localparam logic [2:0] K_READ = 3'd2;  // canvas read, returns a result
    localparam logic [2:0] K_FEND = 3'd3;  // frame end, returns a result
    localparam logic [2:0] K_SNAP = 3'd4;  // copy canvas to saved canvas
    localparam logic [2:0] K_REST = 3'd5;  // copy saved canvas to canvas
    localparam logic [2:0] K_CLR  = 3'd6;  // clear one canvas pixel
    localparam logic [2:0] K_INIT = 3'd7;  // post-reset zero fill

    localparam logic [15:0] DEFAULT_DELAY = 16'd10;
    localparam logic [1:0]  DISP_CLEAR    = 2'd2;
    localparam logic [1:0]  DISP_RESTORE  = 2'd3;

    typedef struct packed {
        logic [2:0]         kind;
        logic               ok;      // read in range / clear pixel on canvas
        logic [ADDR_W-1:0]  addr;
        logic [7:0]         cidx;
        logic [23:0]        rgb;
        logic [31:0]        start;
        logic [15:0]        dur;
        logic [1:0]         disp;
        logic [COORD_W-1:0] left;
        logic [COORD_W-1:0] top;
        logic [COORD_W-1:0] cw;
        logic [COORD_W-1:0] ch;
    } cmd_t;

    typedef struct packed {
        logic [COORD_W-1:0] w;
        logic [COORD_W-1:0] h;
    } geom_t;

endpackage

// ===== sv/gfc_queue.sv =====
// ----------------------------------------------------------------------------
// gfc_queue
// Short command queue between the front end and the back end.
// ----------------------------------------------------------------------------
module gfc_queue
    import gfc_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic push,
    input  cmd_t push_cmd,
    output logic full,
    input  logic pop,
    output logic empty,
    output cmd_t head
);

    localparam int DEPTH = 4;
    localparam int PTR_W = 2;

    cmd_t             entry_reg [DEPTH];
    logic [PTR_W-1:0] wp_reg;
    logic [PTR_W-1:0] rp_reg;
    logic [PTR_W:0]   count_reg;

    assign full  = (count_reg == (PTR_W+1)'(DEPTH));
    assign empty = (count_reg == '0);
    assign head  = entry_reg[rp_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wp_reg] <= push_cmd;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg    <= '0;
            rp_reg    <= '0;
            count_reg <= '0;
        end else begin
            if (push) begin
                wp_reg <= wp_reg + 1'b1;
            end
            if (pop) begin
                rp_reg <= rp_reg + 1'b1;
            end
            count_reg <= count_reg + (PTR_W+1)'(push) - (PTR_W+1)'(pop);
        end
    end

    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        !(push && full)) else $error("queue push while full");
    a_no_underflow: assert property (@(posedge aclk) disable iff (!aresetn)
        !(pop && empty)) else $error("queue pop while empty");
    a_count_step: assert property (@(posedge aclk) disable iff (!aresetn)
        (push && !pop) |=> (count_reg == $past(count_reg) + 1'b1))
        else $error("queue count did not advance on push");

endmodule

// ===== sv/gfc_front.sv =====
// ----------------------------------------------------------------------------
// gfc_front
// Accepts requests, holds the frame header state and the pixel raster
// counters, decides which pixels land on the canvas and computes their
// addresses, and hands the work to the back end as commands.
// ----------------------------------------------------------------------------
module gfc_front
    import gfc_pkg::*;
#(
    parameter int MAX_WIDTH     = 256,
    parameter int MAX_HEIGHT    = 256,
    parameter int PALETTE_DEPTH = 256
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [143:0] s_tdata,
    input  logic [2:0]   s_tuser,
    input  logic         cfg_wr_en,
    input  logic         cfg_index,
    input  logic [8:0]   cfg_wdata,
    input  logic         back_busy,
    input  logic         q_full,
    output logic         push,
    output cmd_t         push_cmd,
    output geom_t        geom
);

    localparam int WW          = $clog2(MAX_WIDTH + 1);
    localparam int HW          = $clog2(MAX_HEIGHT + 1);
    localparam int STORE_DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW          = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
    localparam int PDW         = $clog2(PALETTE_DEPTH + 1);
    localparam int MW          = WW + HW + 1;

    localparam logic [2:0] REQ_PAL  = 3'd0;
    localparam logic [2:0] REQ_HDR  = 3'd1;
    localparam logic [2:0] REQ_PIX  = 3'd2;
    localparam logic [2:0] REQ_READ = 3'd3;
    localparam logic [2:0] REQ_FEND = 3'd4;

    // request fields
    logic [7:0]  cidx;
    logic [23:0] rgb;
    logic [15:0] fl, ft, fw, fh, dl, raddr;
    logic [1:0]  disp;
    logic        ten;
    logic [8:0]  pc;

    assign cidx  = s_tdata[7:0];
    assign rgb   = s_tdata[31:8];
    assign fl    = s_tdata[47:32];
    assign ft    = s_tdata[63:48];
    assign fw    = s_tdata[79:64];
    assign fh    = s_tdata[95:80];
    assign disp  = s_tdata[97:96];
    assign ten   = s_tdata[98];
    assign pc    = s_tdata[107:99];
    assign dl    = s_tdata[123:108];
    assign raddr = s_tdata[139:124];

    logic [8:0]      cfg_w_reg, cfg_h_reg;
    logic [WW-1:0]   w_eff;
    logic [HW-1:0]   h_eff;
    logic [WW+HW-1:0] area;

    logic [WW-1:0]  left_reg, left_next, cw_reg, cw_next;
    logic [HW-1:0]  top_reg, top_next, ch_reg, ch_next;
    logic [15:0]    coded_w_reg, coded_w_next;
    logic [15:0]    col_reg, col_next, row_reg, row_next;
    logic [1:0]     disp_reg, disp_next;
    logic           ten_reg, ten_next;
    logic [7:0]     tidx_reg, tidx_next;
    logic [PDW-1:0] valid_reg, valid_next;
    logic [15:0]    delay_reg, delay_next;
    logic [31:0]    time_reg, time_next;

    logic           accept;
    logic [WW-1:0]  w_rem;
    logic [HW-1:0]  h_rem;
    logic           pix_en, pix_in;
    logic [WW:0]    px;
    logic [HW:0]    py;
    logic [MW-1:0]  prod;
    logic [MW-1:0]  pix_addr;
    logic [16:0]    col_p1;

    always_comb begin
        if (cfg_w_reg == '0) begin
            w_eff = WW'(1);
        end else if (32'(cfg_w_reg) > 32'(MAX_WIDTH)) begin
            w_eff = WW'(MAX_WIDTH);
        end else begin
            w_eff = WW'(cfg_w_reg);
        end
        if (cfg_h_reg == '0) begin
            h_eff = HW'(1);
        end else if (32'(cfg_h_reg) > 32'(MAX_HEIGHT)) begin
            h_eff = HW'(MAX_HEIGHT);
        end else begin
            h_eff = HW'(cfg_h_reg);
        end
    end

    assign geom.w = COORD_W'(w_eff);
    assign geom.h = COORD_W'(h_eff);

    assign s_tready = !back_busy && !q_full;
    assign accept   = s_tvalid && s_tready;

    // pixel placement
    assign pix_en = (32'(col_reg) < 32'(cw_reg)) && (32'(row_reg) < 32'(ch_reg))
                    && !(ten_reg && (cidx == tidx_reg)) && (32'(cidx) < 32'(valid_reg));
    assign px     = (WW+1)'(left_reg) + (WW+1)'(col_reg[WW-1:0]);
    assign py     = (HW+1)'(top_reg) + (HW+1)'(row_reg[HW-1:0]);
    assign pix_in = (32'(px) < 32'(w_eff)) && (32'(py) < 32'(h_eff));
    assign prod   = MW'(py) * MW'(w_eff);
    assign pix_addr = prod + MW'(px);
    assign col_p1 = 17'(col_reg) + 17'd1;
    assign area   = (WW+HW)'(w_eff) * (WW+HW)'(h_eff);

    always_comb begin
        left_next    = left_reg;
        top_next     = top_reg;
        cw_next      = cw_reg;
        ch_next      = ch_reg;
        coded_w_next = coded_w_reg;
        col_next     = col_reg;
        row_next     = row_reg;
        disp_next    = disp_reg;
        ten_next     = ten_reg;
        tidx_next    = tidx_reg;
        valid_next   = valid_reg;
        delay_next   = delay_reg;
        time_next    = time_reg;
        w_rem        = '0;
        h_rem        = '0;
        push         = 1'b0;
        push_cmd     = '0;
        push_cmd.cidx = cidx;
        push_cmd.rgb  = rgb;

        if (accept) begin
            case (s_tuser)
                REQ_PAL: begin
                    push_cmd.kind = K_PAL;
                    push = (32'(cidx) < 32'(PALETTE_DEPTH));
                end
                REQ_HDR: begin
                    left_next = (32'(fl) < 32'(w_eff)) ? WW'(fl) : w_eff;
                    top_next  = (32'(ft) < 32'(h_eff)) ? HW'(ft) : h_eff;
                    w_rem     = w_eff - left_next;
                    h_rem     = h_eff - top_next;
                    cw_next   = (32'(fw) < 32'(w_rem)) ? WW'(fw) : w_rem;
                    ch_next   = (32'(fh) < 32'(h_rem)) ? HW'(fh) : h_rem;
                    coded_w_next = fw;
                    col_next  = '0;
                    row_next  = '0;
                    disp_next = disp;
                    ten_next  = ten;
                    tidx_next = cidx;
                    valid_next = (32'(pc) < 32'(PALETTE_DEPTH)) ? PDW'(pc)
                                                               : PDW'(PALETTE_DEPTH);
                    delay_next = (dl == '0) ? DEFAULT_DELAY : dl;
                    // snapshot the canvas before this frame draws
                    push_cmd.kind = K_SNAP;
                    push = (disp == DISP_RESTORE);
                end
                REQ_PIX: begin
                    push_cmd.kind = K_PIX;
                    push_cmd.addr = ADDR_W'(pix_addr[AW-1:0]);
                    push = pix_en && pix_in;
                    if (col_p1 >= 17'(coded_w_reg)) begin
                        col_next = '0;
                        if (row_reg != 16'hFFFF) begin
                            row_next = row_reg + 16'd1;
                        end
                    end else begin
                        col_next = col_p1[15:0];
                    end
                end
                REQ_READ: begin
                    push_cmd.kind = K_READ;
                    push_cmd.addr = ADDR_W'(raddr);
                    push_cmd.ok   = (32'(raddr) < 32'(area));
                    push = 1'b1;
                end
                REQ_FEND: begin
                    push_cmd.kind  = K_FEND;
                    push_cmd.start = time_reg;
                    push_cmd.dur   = delay_reg;
                    push_cmd.disp  = disp_reg;
                    push_cmd.left  = COORD_W'(left_reg);
                    push_cmd.top   = COORD_W'(top_reg);
                    push_cmd.cw    = COORD_W'(cw_reg);
                    push_cmd.ch    = COORD_W'(ch_reg);
                    time_next = time_reg + 32'(delay_reg);
                    push = 1'b1;
                end
                default: begin
                    push = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_w_reg   <= 9'd256;
            cfg_h_reg   <= 9'd256;
            left_reg    <= '0;
            top_reg     <= '0;
            cw_reg      <= '0;
            ch_reg      <= '0;
            coded_w_reg <= '0;
            col_reg     <= '0;
            row_reg     <= '0;
            disp_reg    <= '0;
            ten_reg     <= 1'b0;
            tidx_reg    <= '0;
            valid_reg   <= '0;
            delay_reg   <= DEFAULT_DELAY;
            time_reg    <= '0;
        end else begin
            if (cfg_wr_en) begin
                if (cfg_index) begin
                    cfg_h_reg <= cfg_wdata;
                end else begin
                    cfg_w_reg <= cfg_wdata;
                end
            end
            left_reg    <= left_next;
            top_reg     <= top_next;
            cw_reg      <= cw_next;
            ch_reg      <= ch_next;
            coded_w_reg <= coded_w_next;
            col_reg     <= col_next;
            row_reg     <= row_next;
            disp_reg    <= disp_next;
            ten_reg     <= ten_next;
            tidx_reg    <= tidx_next;
            valid_reg   <= valid_next;
            delay_reg   <= delay_next;
            time_reg    <= time_next;
        end
    end

endmodule

// ===== sv/gfc_back.sv =====
// ----------------------------------------------------------------------------
// gfc_back
// Executes commands: palette and canvas memories, snapshot, restore and
// clear walks, the post-reset fill, and the result output register.
// ----------------------------------------------------------------------------
module gfc_back
    import gfc_pkg::*;
#(
    parameter int MAX_WIDTH     = 256,
    parameter int MAX_HEIGHT    = 256,
    parameter int PALETTE_DEPTH = 256
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        q_empty,
    input  cmd_t        head,
    output logic        pop,
    input  geom_t       geom,
    output logic        busy,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [79:0] m_tdata,
    output logic        m_tuser
);

    localparam int WW          = $clog2(MAX_WIDTH + 1);
    localparam int HW          = $clog2(MAX_HEIGHT + 1);
    localparam int STORE_DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW          = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
    localparam int PW          = (PALETTE_DEPTH > 1) ? $clog2(PALETTE_DEPTH) : 1;
    localparam int MW          = WW + HW + 1;
    localparam logic [AW-1:0] LAST_ADDR = AW'(STORE_DEPTH - 1);

    localparam logic [2:0] ST_INIT  = 3'd0;
    localparam logic [2:0] ST_RUN   = 3'd1;
    localparam logic [2:0] ST_COPY  = 3'd2;
    localparam logic [2:0] ST_REST  = 3'd3;
    localparam logic [2:0] ST_CLEAR = 3'd4;
    localparam logic [2:0] ST_GAP   = 3'd5;

    logic [2:0]    state_reg, state_next;
    logic [AW-1:0] idx_reg, idx_next;
    logic [WW-1:0] cx_reg, cx_next;
    logic [HW-1:0] cy_reg, cy_next;
    cmd_t          rect_reg, rect_next;

    cmd_t iss;
    logic iss_v;
    cmd_t op1_reg, op2_reg, op3_reg;
    logic v1_reg, v2_reg, v3_reg;

    logic [23:0] palette_mem [PALETTE_DEPTH];
    logic [24:0] canvas_mem  [STORE_DEPTH];
    logic [24:0] saved_mem   [STORE_DEPTH];
    logic [23:0] pal_q_reg;
    logic [24:0] cv_q_reg, sv_q_reg;

    logic        m_tvalid_reg;
    logic [79:0] m_tdata_reg;
    logic        m_tuser_reg;

    logic        res_busy, head_res;
    logic [WW:0] cxa;
    logic [HW:0] cya;
    logic [MW-1:0] clr_addr;
    logic [AW-1:0] a2, a3;

    function automatic logic is_res(input logic v, input logic [2:0] k);
        return v && ((k == K_READ) || (k == K_FEND));
    endfunction

    assign res_busy = is_res(v1_reg, op1_reg.kind) || is_res(v2_reg, op2_reg.kind)
                      || is_res(v3_reg, op3_reg.kind) || m_tvalid_reg;
    assign head_res = (head.kind == K_READ) || (head.kind == K_FEND);
    assign busy     = (state_reg == ST_INIT);

    assign cxa      = (WW+1)'(rect_reg.left) + (WW+1)'(cx_reg);
    assign cya      = (HW+1)'(rect_reg.top) + (HW+1)'(cy_reg);
    assign clr_addr = MW'(cya) * MW'(geom.w) + MW'(cxa);

    // walk sequencer and command issue
    always_comb begin
        state_next = state_reg;
        idx_next   = idx_reg;
        cx_next    = cx_reg;
        cy_next    = cy_reg;
        rect_next  = rect_reg;
        iss        = head;
        iss_v      = 1'b0;
        pop        = 1'b0;
        case (state_reg)
            ST_INIT: begin
                iss.kind = K_INIT;
                iss.addr = ADDR_W'(idx_reg);
                iss_v    = 1'b1;
                idx_next = idx_reg + 1'b1;
                if (idx_reg == LAST_ADDR) begin
                    idx_next   = '0;
                    state_next = ST_RUN;
                end
            end
            ST_RUN: begin
                if (!q_empty && !(head_res && res_busy)) begin
                    pop = 1'b1;
                    case (head.kind)
                        K_SNAP: begin
                            idx_next   = '0;
                            state_next = ST_COPY;
                        end
                        K_FEND: begin
                            iss_v     = 1'b1;
                            rect_next = head;
                            cx_next   = '0;
                            cy_next   = '0;
                            idx_next  = '0;
                            if (head.disp == DISP_CLEAR && head.cw != '0 && head.ch != '0) begin
                                state_next = ST_CLEAR;
                            end else if (head.disp == DISP_RESTORE) begin
                                state_next = ST_REST;
                            end
                        end
                        default: begin
                            iss_v = 1'b1;
                        end
                    endcase
                end
            end
            ST_COPY, ST_REST: begin
                iss.kind = (state_reg == ST_COPY) ? K_SNAP : K_REST;
                iss.addr = ADDR_W'(idx_reg);
                iss_v    = 1'b1;
                idx_next = idx_reg + 1'b1;
                if (idx_reg == LAST_ADDR) begin
                    idx_next   = '0;
                    state_next = ST_GAP;
                end
            end
            ST_CLEAR: begin
                iss.kind = K_CLR;
                iss.addr = ADDR_W'(clr_addr[AW-1:0]);
                iss.ok   = (32'(cxa) < 32'(geom.w)) && (32'(cya) < 32'(geom.h));
                iss_v    = 1'b1;
                if (32'(cx_reg) == 32'(rect_reg.cw) - 32'd1) begin
                    cx_next = '0;
                    cy_next = cy_reg + 1'b1;
                    if (32'(cy_reg) == 32'(rect_reg.ch) - 32'd1) begin
                        state_next = ST_GAP;
                    end
                end else begin
                    cx_next = cx_reg + 1'b1;
                end
            end
            ST_GAP: begin
                // let the last walk write retire before the next canvas access
                state_next = ST_RUN;
            end
            default: begin
                state_next = ST_RUN;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_INIT;
            idx_reg   <= '0;
            cx_reg    <= '0;
            cy_reg    <= '0;
            v1_reg    <= 1'b0;
            v2_reg    <= 1'b0;
            v3_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            cx_reg    <= cx_next;
            cy_reg    <= cy_next;
            v1_reg    <= iss_v;
            v2_reg    <= v1_reg;
            v3_reg    <= v2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        rect_reg <= rect_next;
        op1_reg  <= iss;
        op2_reg  <= op1_reg;
        op3_reg  <= op2_reg;
    end

    // palette: write and read in the first stage
    always_ff @(posedge aclk) begin
        if (v1_reg && op1_reg.kind == K_PAL) begin
            palette_mem[op1_reg.cidx[PW-1:0]] <= op1_reg.rgb;
        end
        pal_q_reg <= palette_mem[op1_reg.cidx[PW-1:0]];
    end

    assign a2 = op2_reg.addr[AW-1:0];
    assign a3 = op3_reg.addr[AW-1:0];

    // canvas: pixel, clear and fill writes in stage two, restore writes in stage three
    always_ff @(posedge aclk) begin
        if (v3_reg && op3_reg.kind == K_REST) begin
            canvas_mem[a3] <= sv_q_reg;
        end else if (v2_reg && op2_reg.kind == K_PIX) begin
            canvas_mem[a2] <= {1'b1, pal_q_reg};
        end else if (v2_reg && ((op2_reg.kind == K_CLR && op2_reg.ok)
                                || op2_reg.kind == K_INIT)) begin
            canvas_mem[a2] <= '0;
        end
        cv_q_reg <= canvas_mem[a2];
    end

    always_ff @(posedge aclk) begin
        if (v3_reg && op3_reg.kind == K_SNAP) begin
            saved_mem[a3] <= cv_q_reg;
        end else if (v2_reg && op2_reg.kind == K_INIT) begin
            saved_mem[a2] <= '0;
        end
        sv_q_reg <= saved_mem[a2];
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (is_res(v3_reg, op3_reg.kind)) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (is_res(v3_reg, op3_reg.kind)) begin
            if (op3_reg.kind == K_FEND) begin
                m_tuser_reg <= 1'b1;
                m_tdata_reg <= {op3_reg.dur, op3_reg.start, 32'd0};
            end else begin
                m_tuser_reg <= 1'b0;
                m_tdata_reg <= {48'd0, (op3_reg.ok && cv_q_reg[24]) ? 8'hFF : 8'h00,
                                op3_reg.ok ? cv_q_reg[23:0] : 24'd0};
            end
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    a_one_canvas_write: assert property (@(posedge aclk) disable iff (!aresetn)
        !(v3_reg && op3_reg.kind == K_REST && v2_reg &&
          (op2_reg.kind == K_PIX || op2_reg.kind == K_CLR || op2_reg.kind == K_INIT)))
        else $error("two canvas writes in one cycle");
    a_result_slot_free: assert property (@(posedge aclk) disable iff (!aresetn)
        is_res(v3_reg, op3_reg.kind) |-> !m_tvalid_reg)
        else $error("result arrived at a full output register");
    a_no_pop_in_fill: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_INIT) |-> !pop)
        else $error("command taken during the post-reset fill");

endmodule

// ===== sv/gif_frame_compositor_top.sv =====
// ----------------------------------------------------------------------------
// gif_frame_compositor_top
// Composites decoded GIF frames onto an RGBA canvas with disposal handling.
// ----------------------------------------------------------------------------
// Palette writes, frame headers and pixel indices are taken one per cycle
// while the queue has room; a canvas read or frame end goes through the
// memory pipeline and the result register to the output handshake, and
// only one result is in flight at a time. A header with restore-previous
// disposal and a frame end with restore-previous each walk the whole
// store; a frame end with clear-to-background walks the clipped rectangle.
// Those walks follow from the single write port of the canvas memory; the
// front end keeps queuing up to four commands meanwhile. After reset a
// zero-fill pass runs over every location of both canvas stores, and no
// request is taken until it ends (configuration writes are taken
// throughout).
// ----------------------------------------------------------------------------
module gif_frame_compositor_top
    import gfc_pkg::*;
#(
    parameter int MAX_WIDTH     = 256,
    parameter int MAX_HEIGHT    = 256,
    parameter int PALETTE_DEPTH = 256
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // color_index, palette_rgb, frame_left, frame_top, frame_width,
    // frame_height, disposal, transparent_enable, palette_count, delay_cs,
    // canvas_address, zero padding
    input  logic [143:0] s_tdata,
    // req_type
    input  logic [2:0]   s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // pixel_rgba, frame_start_cs, frame_duration_cs
    output logic [79:0]  m_tdata,
    // result_kind
    output logic         m_tuser,
    input  logic         cfg_wr_en,
    input  logic         cfg_index,
    input  logic [8:0]   cfg_wdata
);

    logic  back_busy, q_full, q_empty, push, pop;
    cmd_t  push_cmd, head;
    geom_t geom;

    gfc_front #(
        .MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT), .PALETTE_DEPTH(PALETTE_DEPTH)
    ) u_front (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
        .back_busy(back_busy), .q_full(q_full), .push(push), .push_cmd(push_cmd),
        .geom(geom)
    );

    gfc_queue u_queue (
        .aclk(aclk), .aresetn(aresetn),
        .push(push), .push_cmd(push_cmd), .full(q_full),
        .pop(pop), .empty(q_empty), .head(head)
    );

    gfc_back #(
        .MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT), .PALETTE_DEPTH(PALETTE_DEPTH)
    ) u_back (
        .aclk(aclk), .aresetn(aresetn),
        .q_empty(q_empty), .head(head), .pop(pop), .geom(geom), .busy(back_busy),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
    );

endmodule
